// File: src/gcd_pkg.sv
`default_nettype none
package gcd_pkg;

  // CORDIC and square-root datapath widths
  localparam int XY_W = 34;
  localparam int Z_W  = 33;
  localparam int SQ_W = 64;

  localparam logic signed [XY_W-1:0] TURN_D23  = 34'sd3019898880;
  localparam logic signed [XY_W-1:0] HALF_D23  = 34'sd1509949440;
  localparam logic signed [XY_W-1:0] QUART_D23 = 34'sd754974720;
  localparam logic [29:0]            DEG2RAD_K = 30'd599690565;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [30:0]            ONE_Q30   = 31'd1073741824;
  localparam logic [13:0]            TWO_R_KM  = 14'd12742;
  localparam logic [30:0]            DIST_MAX  = 31'd1311768576;

  // truncated Q30 arctangent of 2^-i
  function automatic logic signed [Z_W-1:0] atan_at(input int i);
    logic [31:0] a;
    case (i)
      0:  a = 32'h3243F6A8;
      1:  a = 32'h1DAC6705;
      2:  a = 32'h0FADBAFC;
      3:  a = 32'h07F56EA6;
      4:  a = 32'h03FEAB76;
      5:  a = 32'h01FFD55B;
      6:  a = 32'h00FFFAAA;
      7:  a = 32'h007FFF55;
      8:  a = 32'h003FFFEA;
      9:  a = 32'h001FFFFD;
      10: a = 32'h000FFFFF;
      11: a = 32'h0007FFFF;
      12: a = 32'h0003FFFF;
      13: a = 32'h0001FFFF;
      14: a = 32'h0000FFFF;
      15: a = 32'h00007FFF;
      16: a = 32'h00003FFF;
      17: a = 32'h00001FFF;
      18: a = 32'h00000FFF;
      19: a = 32'h000007FF;
      20: a = 32'h000003FF;
      21: a = 32'h000001FF;
      22: a = 32'h000000FF;
      23: a = 32'h0000007F;
      24: a = 32'h0000003F;
      25: a = 32'h0000001F;
      26: a = 32'h0000000F;
      27: a = 32'h00000008;
      28: a = 32'h00000004;
      29: a = 32'h00000002;
      30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return $signed({1'b0, a});
  endfunction

endpackage
`default_nettype wire

// File: src/great_circle_distance_unit.sv
`default_nettype none
// Haversine great-circle distance, fully pipelined: one coordinate pair is
// taken every cycle while the output is not stalled. The pipe is built from
// rows of CORDIC cells (four rotation rows for sin/cos, one vectoring row for
// half the central angle, ITERATIONS cells each) and the two 32-digit
// square-root rows. A stall at the output freezes the whole pipe; in_ready_o
// follows out_ready_i whenever a result is held. Output is km * 2^16,
// saturating.
module great_circle_distance_unit #(
  parameter int ITERATIONS = 24
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire logic signed [29:0] lat_a_i,
  input  wire logic signed [30:0] lon_a_i,
  input  wire logic signed [29:0] lat_b_i,
  input  wire logic signed [30:0] lon_b_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic [30:0]       distance_km_o
);
  import gcd_pkg::*;

  localparam int N   = ITERATIONS;
  localparam int LAT = 2 * N + 40;

  logic en;
  logic [LAT-1:0] vld_q;
  logic out_valid_q;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;

  // stage valids: whole pipe advances together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[LAT-2:0], in_valid_i};
      out_valid_q <= vld_q[LAT-1];
    end
  end

  // input register
  logic signed [29:0] la_q, lb_q;
  logic signed [30:0] oa_q, ob_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      la_q <= lat_a_i;
      oa_q <= lon_a_i;
      lb_q <= lat_b_i;
      ob_q <= lon_b_i;
    end
  end

  // lanes: 0 dlat, 1 dlon (sines); 2 lat_a*2, 3 lat_b*2 (cosines)
  logic signed [XY_W-1:0] ang_q [4];
  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q[0] <= XY_W'(lb_q) - XY_W'(la_q);
      ang_q[1] <= XY_W'(ob_q) - XY_W'(oa_q);
      ang_q[2] <= XY_W'(la_q) <<< 1;
      ang_q[3] <= XY_W'(lb_q) <<< 1;
    end
  end

  // wrap to one turn, fold into [-90, 90] degrees
  logic [29:0] mag_q [4];
  logic [3:0]  sgn_q, neg_q;
  always_ff @(posedge clk_i) begin
    logic signed [XY_W-1:0] r;
    logic                   flip;
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        r = ang_q[l];
        flip = 1'b0;
        if (r >= HALF_D23)       r = r - TURN_D23;
        else if (r < -HALF_D23)  r = r + TURN_D23;
        if (r > QUART_D23) begin
          r = HALF_D23 - r;
          flip = 1'b1;
        end else if (r < -QUART_D23) begin
          r = -HALF_D23 - r;
          flip = 1'b1;
        end
        neg_q[l] <= flip;
        sgn_q[l] <= r[XY_W-1];
        mag_q[l] <= r[XY_W-1] ? 30'(-r) : 30'(r);
      end
    end
  end

  // degrees to radians
  logic [59:0] prod_q [4];
  logic [3:0]  sgn2_q, neg2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 4; l++) prod_q[l] <= 60'(mag_q[l]) * 60'(DEG2RAD_K);
      sgn2_q <= sgn_q;
      neg2_q <= neg_q;
    end
  end

  logic signed [XY_W-1:0] rx [4][N+1];
  logic signed [XY_W-1:0] ry [4][N+1];
  logic signed [Z_W-1:0]  rz [4][N+1];
  logic [1:0]             negd_q [N];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [Z_W-1:0] zm;
    assign zm       = Z_W'((prod_q[l] + 60'(1 << 27)) >> 28);
    assign rx[l][0] = CORDIC_GAIN;
    assign ry[l][0] = '0;
    assign rz[l][0] = sgn2_q[l] ? -$signed(zm) : $signed(zm);
    for (genvar k = 0; k < N; k++) begin : g_cell
      gcd_cordic_cell #(.STEP(k), .VECTOR(1'b0)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .x_i   (rx[l][k]),
        .y_i   (ry[l][k]),
        .z_i   (rz[l][k]),
        .x_o   (rx[l][k+1]),
        .y_o   (ry[l][k+1]),
        .z_o   (rz[l][k+1])
      );
    end
  end

  // cosine sign flags ride alongside the rotation rows
  always_ff @(posedge clk_i) begin
    if (en) begin
      negd_q[0] <= neg2_q[3:2];
      for (int k = 1; k < N; k++) negd_q[k] <= negd_q[k-1];
    end
  end

  // haversine term
  logic signed [XY_W-1:0] c1, c2;
  logic signed [2*XY_W-1:0] uu_full, vv_full, p_full;
  assign c1      = negd_q[N-1][0] ? -rx[2][N] : rx[2][N];
  assign c2      = negd_q[N-1][1] ? -rx[3][N] : rx[3][N];
  assign uu_full = ry[0][N] * ry[0][N];
  assign vv_full = ry[1][N] * ry[1][N];
  assign p_full  = c1 * c2;

  logic signed [Z_W-1:0] uu_q, vv_q, p_q, uu2_q, q_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      uu_q <= Z_W'(uu_full >>> 30);
      vv_q <= Z_W'(vv_full >>> 30);
      p_q  <= Z_W'(p_full >>> 30);
    end
  end

  logic signed [2*Z_W-1:0] q_full;
  assign q_full = p_q * vv_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      q_q   <= Z_W'(q_full >>> 30);
      uu2_q <= uu_q;
    end
  end

  logic signed [Z_W:0] term_s;
  logic [30:0]         term_q;
  assign term_s = (Z_W+1)'(uu2_q) + (Z_W+1)'(q_q);
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (term_s < 0)                              term_q <= '0;
      else if (term_s > $signed({3'b0, ONE_Q30}))  term_q <= ONE_Q30;
      else                                         term_q <= term_s[30:0];
    end
  end

  // square roots of term and 1 - term
  logic [SQ_W-1:0] sv [2][33];
  logic [SQ_W-1:0] sr [2][33];
  assign sv[0][0] = SQ_W'(term_q) << 30;
  assign sv[1][0] = SQ_W'(ONE_Q30 - term_q) << 30;
  assign sr[0][0] = '0;
  assign sr[1][0] = '0;

  for (genvar j = 0; j < 2; j++) begin : g_root
    for (genvar k = 0; k < 32; k++) begin : g_cell
      gcd_sqrt_cell #(.DIGIT(k)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .v_i   (sv[j][k]),
        .res_i (sr[j][k]),
        .v_o   (sv[j][k+1]),
        .res_o (sr[j][k+1])
      );
    end
  end

  // half the central angle = atan2(sqrt(term), sqrt(1 - term))
  logic signed [XY_W-1:0] vx [N+1];
  logic signed [XY_W-1:0] vy [N+1];
  logic signed [Z_W-1:0]  vz [N+1];
  assign vx[0] = $signed({2'b0, sr[1][32][31:0]});
  assign vy[0] = $signed({2'b0, sr[0][32][31:0]});
  assign vz[0] = '0;

  for (genvar k = 0; k < N; k++) begin : g_vec
    gcd_cordic_cell #(.STEP(k), .VECTOR(1'b1)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (vx[k]),
      .y_i   (vy[k]),
      .z_i   (vz[k]),
      .x_o   (vx[k+1]),
      .y_o   (vy[k+1]),
      .z_o   (vz[k+1])
    );
  end

  // distance = 2R * angle, rounded, saturated
  logic [Z_W-2:0]  ang_c;
  logic [Z_W+13:0] dprod_q;
  logic [Z_W+13:0] dround;
  assign ang_c  = vz[N][Z_W-1] ? '0 : vz[N][Z_W-2:0];
  assign dround = (dprod_q + (Z_W+14)'(1 << 13)) >> 14;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dprod_q <= (Z_W+14)'(ang_c) * (Z_W+14)'(TWO_R_KM);
      if (dround > (Z_W+14)'(DIST_MAX)) distance_km_o <= DIST_MAX;
      else                               distance_km_o <= dround[30:0];
    end
  end
endmodule
`default_nettype wire

// File: src/gcd_cordic_cell.sv
`default_nettype none
module gcd_cordic_cell #(
  parameter int STEP   = 0,
  parameter bit VECTOR = 1'b0
) (
  input  wire                                  clk_i,
  input  wire                                  en_i,
  input  wire logic signed [gcd_pkg::XY_W-1:0] x_i,
  input  wire logic signed [gcd_pkg::XY_W-1:0] y_i,
  input  wire logic signed [gcd_pkg::Z_W-1:0]  z_i,
  output logic signed [gcd_pkg::XY_W-1:0]      x_o,
  output logic signed [gcd_pkg::XY_W-1:0]      y_o,
  output logic signed [gcd_pkg::Z_W-1:0]       z_o
);
  import gcd_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = atan_at(STEP);

  logic                    up;
  logic signed [XY_W-1:0]  xs, ys, x_d, y_d;
  logic signed [Z_W-1:0]   z_d;

  // rotation steers on the residual angle, vectoring on the sign of y
  assign up = VECTOR ? (y_i <= 0) : (z_i >= 0);
  assign xs = x_i >>> STEP;
  assign ys = y_i >>> STEP;

  always_comb begin
    if (up) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
    end
    if (up) z_d = z_i - ATAN;
    else    z_d = z_i + ATAN;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o <= x_d;
      y_o <= y_d;
      z_o <= z_d;
    end
  end
endmodule
`default_nettype wire

// File: src/gcd_sqrt_cell.sv
`default_nettype none
module gcd_sqrt_cell #(
  parameter int DIGIT = 0
) (
  input  wire                             clk_i,
  input  wire                             en_i,
  input  wire logic [gcd_pkg::SQ_W-1:0]   v_i,
  input  wire logic [gcd_pkg::SQ_W-1:0]   res_i,
  output logic [gcd_pkg::SQ_W-1:0]        v_o,
  output logic [gcd_pkg::SQ_W-1:0]        res_o
);
  import gcd_pkg::*;

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (62 - 2 * DIGIT);

  logic [SQ_W-1:0] trial;

  assign trial = res_i + BIT;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (v_i >= trial) begin
        v_o   <= v_i - trial;
        res_o <= (res_i >> 1) + BIT;
      end else begin
        v_o   <= v_i;
        res_o <= res_i >> 1;
      end
    end
  end
endmodule
`default_nettype wire

// File: src/gcd_checker.sv
`default_nettype none
module gcd_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_ready_o,
  input wire        out_valid_o,
  input wire        out_ready_i,
  input wire [30:0] distance_km_o
);
  import gcd_pkg::*;

  // a held result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_km_o))
    else $error("held result changed");

  // saturation limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> distance_km_o <= DIST_MAX)
    else $error("distance beyond limit");

  // the pipe only stalls while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input stalled without output backpressure");

  // nothing comes out right after reset with no items taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result without item");
endmodule

bind great_circle_distance_unit gcd_checker u_gcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .distance_km_o (distance_km_o)
);
`default_nettype wire
